FILE: rtl/core/bfc_pkg.sv
package bfc_pkg;

    localparam int SPAN_BITS_DEF = 10;
    localparam int GREY_BITS     = 8;
    localparam int CFG_ADDR_BITS = 3;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_ROW_SPAN  = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_COL_SPAN  = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_CORNER_TL = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_CORNER_TR = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_CORNER_BL = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_CORNER_BR = 3'd5;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_TOLERANCE = 3'd6;

    typedef struct packed {
        logic [GREY_BITS-1:0] pixel;
        logic                 marked;
    } t_in_item;

    typedef struct packed {
        logic [GREY_BITS-1:0] predicted;
        logic                 pixel_fits;
        logic                 block_fits;
        logic                 last;
    } t_out_item;

endpackage

FILE: rtl/core/bfc_div.sv
module bfc_div #(
    parameter int NUM_W = 18,
    parameter int DEN_W = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo,
    output logic             o_rem_nz
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quo;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   rem_shift;
    logic             take;

    // one quotient bit per cycle, restoring
    assign rem_shift = {r_rem[DEN_W-1:0], r_quo[NUM_W-1]};
    assign take      = (rem_shift >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= CNT_W'(NUM_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_quo <= {r_quo[NUM_W-2:0], take};
                r_rem <= take ? (rem_shift - {1'b0, r_den}) : rem_shift;
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_quo    = r_quo;
    assign o_rem_nz = |r_rem;

endmodule

FILE: rtl/core/bilinear_block_fit_check.sv
// Bilinear block fit check. Program the spans, four corners and tolerance
// through the write port while the block is idle, then stream the block's
// pixels in raster order; each pixel gives one item with its prediction,
// its own fit flag, the running block verdict and a last flag, after which
// position and verdict return to the top left for the next block. Each pixel
// takes three interpolations (left edge, right edge, then across the row),
// all run on one shared restoring divider that yields one quotient bit per
// cycle. The input is stalled until the pixel's item is finished and taken
// into the output register; the result sits there so the next pixel can be
// taken while it waits, and a finished item that finds that register still
// full holds until it drains.
module bilinear_block_fit_check #(
    parameter int SPAN_BITS = bfc_pkg::SPAN_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  bfc_pkg::t_in_item                     i_in_item,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output bfc_pkg::t_out_item                    o_out_item,
    input  logic                                  i_cfg_we,
    input  logic [bfc_pkg::CFG_ADDR_BITS-1:0]     i_cfg_addr,
    input  logic [(SPAN_BITS > bfc_pkg::GREY_BITS ? SPAN_BITS
                   : bfc_pkg::GREY_BITS)-1:0]     i_cfg_data
);
    import bfc_pkg::*;

    localparam int NUM_W = GREY_BITS + SPAN_BITS;

    typedef enum logic [1:0] {ST_IDLE, ST_START, ST_WAIT, ST_FINISH} t_state;
    typedef enum logic [1:0] {PH_LEFT, PH_RIGHT, PH_PRED} t_phase;

    t_state r_state;
    t_phase r_phase;

    logic [SPAN_BITS-1:0] r_row_span, r_col_span;
    logic [GREY_BITS-1:0] r_tl, r_tr, r_bl, r_br, r_tol;

    logic [SPAN_BITS-1:0] r_row_off, r_col_off;
    logic                 r_verdict;
    logic [GREY_BITS-1:0] r_left, r_right, r_pred;
    logic [GREY_BITS-1:0] r_pixel;
    logic                 r_marked;

    logic       r_out_valid;
    t_out_item  r_out_item;

    // shared interpolation operands
    logic [GREY_BITS-1:0] op_a, op_b;
    logic [SPAN_BITS-1:0] op_k, op_s, k_sat;
    logic                 neg;
    logic [GREY_BITS:0]   diff;
    logic [GREY_BITS-1:0] mag;
    logic [NUM_W-1:0]     product;

    logic                 div_done, div_rem_nz;
    logic [NUM_W-1:0]     div_quo;
    logic [GREY_BITS-1:0] q, lerp_res;

    logic [GREY_BITS-1:0] abs_err;
    logic                 fits, row_end, last, out_free, out_load;

    always_comb begin
        case (r_phase)
            PH_LEFT: begin
                op_a = r_tl; op_b = r_bl; op_k = r_row_off; op_s = r_row_span;
            end
            PH_RIGHT: begin
                op_a = r_tr; op_b = r_br; op_k = r_row_off; op_s = r_row_span;
            end
            default: begin
                op_a = r_left; op_b = r_right; op_k = r_col_off; op_s = r_col_span;
            end
        endcase
    end

    assign k_sat   = (op_k > op_s) ? op_s : op_k;
    assign diff    = {1'b0, op_b} - {1'b0, op_a};
    assign neg     = diff[GREY_BITS];
    assign mag     = neg ? GREY_BITS'(-diff) : diff[GREY_BITS-1:0];
    assign product = NUM_W'(mag) * NUM_W'(k_sat);

    bfc_div #(
        .NUM_W(NUM_W),
        .DEN_W(SPAN_BITS)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == ST_START),
        .i_num    (product),
        .i_den    (op_s),
        .o_done   (div_done),
        .o_quo    (div_quo),
        .o_rem_nz (div_rem_nz)
    );

    // floor toward minus infinity: round the magnitude up when negative
    assign q = div_quo[GREY_BITS-1:0];
    always_comb begin
        if (op_s == '0) begin
            lerp_res = op_a;
        end else if (neg) begin
            lerp_res = op_a - q - GREY_BITS'(div_rem_nz);
        end else begin
            lerp_res = op_a + q;
        end
    end

    assign abs_err  = (r_pixel >= r_pred) ? (r_pixel - r_pred) : (r_pred - r_pixel);
    assign fits     = !r_marked && (abs_err <= r_tol);
    assign row_end  = (r_col_off >= r_col_span);
    assign last     = row_end && (r_row_off >= r_row_span);
    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = (r_state == ST_FINISH) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_span <= '0;
            r_col_span <= '0;
            r_tl       <= '0;
            r_tr       <= '0;
            r_bl       <= '0;
            r_br       <= '0;
            r_tol      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_ROW_SPAN:  r_row_span <= i_cfg_data[SPAN_BITS-1:0];
                CFG_COL_SPAN:  r_col_span <= i_cfg_data[SPAN_BITS-1:0];
                CFG_CORNER_TL: r_tl       <= i_cfg_data[GREY_BITS-1:0];
                CFG_CORNER_TR: r_tr       <= i_cfg_data[GREY_BITS-1:0];
                CFG_CORNER_BL: r_bl       <= i_cfg_data[GREY_BITS-1:0];
                CFG_CORNER_BR: r_br       <= i_cfg_data[GREY_BITS-1:0];
                CFG_TOLERANCE: r_tol      <= i_cfg_data[GREY_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_LEFT;
            r_row_off   <= '0;
            r_col_off   <= '0;
            r_verdict   <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_pixel  <= i_in_item.pixel;
                        r_marked <= i_in_item.marked;
                        r_phase  <= PH_LEFT;
                        r_state  <= ST_START;
                    end
                end
                ST_START: begin
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (div_done) begin
                        unique case (r_phase)
                            PH_LEFT: begin
                                r_left  <= lerp_res;
                                r_phase <= PH_RIGHT;
                                r_state <= ST_START;
                            end
                            PH_RIGHT: begin
                                r_right <= lerp_res;
                                r_phase <= PH_PRED;
                                r_state <= ST_START;
                            end
                            default: begin
                                r_pred  <= lerp_res;
                                r_state <= ST_FINISH;
                            end
                        endcase
                    end
                end
                ST_FINISH: begin
                    // hold until the output register can take the item
                    if (out_free) begin
                        r_out_item.predicted   <= r_pred;
                        r_out_item.pixel_fits  <= fits;
                        r_out_item.block_fits  <= r_verdict & fits;
                        r_out_item.last        <= last;
                        if (last) begin
                            r_row_off <= '0;
                            r_col_off <= '0;
                            r_verdict <= 1'b1;
                        end else if (row_end) begin
                            r_col_off <= '0;
                            r_row_off <= r_row_off + SPAN_BITS'(1);
                            r_verdict <= r_verdict & fits;
                        end else begin
                            r_col_off <= r_col_off + SPAN_BITS'(1);
                            r_verdict <= r_verdict & fits;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: bench/tb_bilinear_block_fit_check.sv
module tb_bilinear_block_fit_check;
    timeunit 1ns;
    timeprecision 1ps;

    import bfc_pkg::*;

    localparam int SPAN_BITS     = SPAN_BITS_DEF;
    localparam int CFG_BITS      = (SPAN_BITS > GREY_BITS) ? SPAN_BITS : GREY_BITS;
    localparam int SPAN_MAX      = (1 << SPAN_BITS) - 1;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 3 * (SPAN_BITS + 10) + 10;
    localparam int RANDOM_PIXELS = 400;
    localparam int HOLD_CYCLES   = 500;

    // No register sits at the top index; writes there must be dropped.
    localparam logic [CFG_ADDR_BITS-1:0] CFG_UNUSED = 3'd7;

    logic                     i_clk     = 1'b0;
    logic                     i_rst_n   = 1'b0;
    logic                     in_valid  = 1'b0;
    t_in_item                 in_item   = '0;
    logic                     out_stall = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr  = CFG_ROW_SPAN;
    logic [CFG_BITS-1:0]      cfg_data  = '0;
    logic                     in_stall;
    logic                     out_valid;
    t_out_item                out_item;

    // Block geometry, corners and tolerance as last written
    logic [SPAN_BITS-1:0] row_span_q, col_span_q;
    logic [7:0]           tl_q, tr_q, bl_q, br_q, tol_q;
    // Position in the current block and running verdict
    logic [SPAN_BITS-1:0] row_pos, col_pos;
    logic                 block_ok;

    t_out_item expected_fits[$];

    int  n_errors     = 0;
    int  n_pixels     = 0;
    int  n_blocks     = 0;
    int  n_cfg_writes = 0;
    logic tx_idle_on  = 1'b1;
    logic rx_idle_on  = 1'b1;
    int  rx_hold_len  = 0;

    bilinear_block_fit_check dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void fit_model_reset();
        row_span_q = '0;
        col_span_q = '0;
        tl_q       = '0;
        tr_q       = '0;
        bl_q       = '0;
        br_q       = '0;
        tol_q      = '0;
        row_pos    = '0;
        col_pos    = '0;
        block_ok   = 1'b1;
    endfunction

    // a + floor((b - a) * k / s), k clamped to s; a zero span holds a
    function automatic logic [7:0] interp_floor(input logic [7:0] a, input logic [7:0] b,
                                                input logic [SPAN_BITS-1:0] k,
                                                input logic [SPAN_BITS-1:0] s);
        int av, bv, span, pos, num, q;
        av   = int'(a);
        bv   = int'(b);
        span = int'(s);
        pos  = int'(k);
        if (span == 0)
            return a;
        if (pos > span)
            pos = span;
        num = (bv - av) * pos;
        if (num >= 0)
            q = num / span;
        else
            q = -((-num + span - 1) / span);
        return 8'(av + q);
    endfunction

    function automatic logic [7:0] prediction_here();
        logic [7:0] left_val, right_val;
        left_val  = interp_floor(tl_q, bl_q, row_pos, row_span_q);
        right_val = interp_floor(tr_q, br_q, row_pos, row_span_q);
        return interp_floor(left_val, right_val, col_pos, col_span_q);
    endfunction

    function automatic t_out_item fit_model_step(input t_in_item px);
        t_out_item  r;
        logic [7:0] pred, err_mag;
        logic       row_end;
        pred         = prediction_here();
        err_mag      = (px.pixel >= pred) ? px.pixel - pred : pred - px.pixel;
        r.predicted  = pred;
        r.pixel_fits = !px.marked && (err_mag <= tol_q);
        block_ok     = block_ok & r.pixel_fits;
        r.block_fits = block_ok;
        row_end      = (col_pos >= col_span_q);
        r.last       = row_end && (row_pos >= row_span_q);
        if (r.last) begin
            row_pos  = '0;
            col_pos  = '0;
            block_ok = 1'b1;
        end else if (row_end) begin
            col_pos = '0;
            row_pos = row_pos + SPAN_BITS'(1);
        end else begin
            col_pos = col_pos + SPAN_BITS'(1);
        end
        return r;
    endfunction

    function automatic void log_error(input string msg);
        n_errors++;
        if (n_errors <= 10)
            $display("%0t ns: %s", $time, msg);
    endfunction

    // Compare every accepted result with the oldest expectation
    initial begin : result_checker
        t_out_item want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_valid && !out_stall) begin
                if (out_item.last)
                    n_blocks++;
                if (expected_fits.size() == 0) begin
                    log_error($sformatf("unexpected item: pred %0d fits %0d block %0d last %0d",
                        out_item.predicted, out_item.pixel_fits, out_item.block_fits,
                        out_item.last));
                end else begin
                    want = expected_fits.pop_front();
                    if (out_item.predicted !== want.predicted ||
                        out_item.pixel_fits !== want.pixel_fits ||
                        out_item.block_fits !== want.block_fits ||
                        out_item.last !== want.last)
                        log_error($sformatf({"mismatch: expected pred %0d fits %0d block %0d ",
                            "last %0d, got pred %0d fits %0d block %0d last %0d"},
                            want.predicted, want.pixel_fits, want.block_fits, want.last,
                            out_item.predicted, out_item.pixel_fits, out_item.block_fits,
                            out_item.last));
                end
            end
        end
    end

    // Output side: random stall bursts, or one long hold on request
    initial begin : result_receiver
        int n;
        forever begin
            @(posedge i_clk);
            if (rx_hold_len != 0) begin
                n           = rx_hold_len;
                rx_hold_len = 0;
                out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                out_stall <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timed out after %0d cycles with %0d results outstanding",
                 cycles, expected_fits.size());
        $display("FAILURE");
        $finish;
    end

    task automatic send_pixel(input logic [7:0] pix, input logic mk);
        t_in_item it;
        it.pixel  = pix;
        it.marked = mk;
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (in_stall);
        expected_fits.push_back(fit_model_step(it));
        n_pixels++;
    endtask

    // Drop valid and wait until every pending result is out
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_fits.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_BITS-1:0] addr,
                             input logic [CFG_BITS-1:0] data);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(posedge i_clk);
        case (addr)
            CFG_ROW_SPAN:  row_span_q = data[SPAN_BITS-1:0];
            CFG_COL_SPAN:  col_span_q = data[SPAN_BITS-1:0];
            CFG_CORNER_TL: tl_q = data[7:0];
            CFG_CORNER_TR: tr_q = data[7:0];
            CFG_CORNER_BL: bl_q = data[7:0];
            CFG_CORNER_BR: br_q = data[7:0];
            CFG_TOLERANCE: tol_q = data[7:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge i_clk);
        n_cfg_writes++;
    endtask

    task automatic set_block(input int rs, input int cs, input int tl, input int tr,
                             input int bl, input int br, input int tol);
        cfg_write(CFG_ROW_SPAN, CFG_BITS'(rs));
        cfg_write(CFG_COL_SPAN, CFG_BITS'(cs));
        cfg_write(CFG_CORNER_TL, CFG_BITS'(tl));
        cfg_write(CFG_CORNER_TR, CFG_BITS'(tr));
        cfg_write(CFG_CORNER_BL, CFG_BITS'(bl));
        cfg_write(CFG_CORNER_BR, CFG_BITS'(br));
        cfg_write(CFG_TOLERANCE, CFG_BITS'(tol));
    endtask

    // All registers at zero: every pixel is a one-pixel block predicted as 0
    task automatic test_reset_state();
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b1);
        send_pixel(8'h5A, 1'b0);
        drain_results();
    endtask

    // Opposite corners at the extremes: falling edges exercise floor of negatives
    task automatic test_corner_extremes();
        set_block(1, 2, 0, 255, 255, 0, 255);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd128, 1'b0);
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        drain_results();
    endtask

    task automatic test_zero_span();
        set_block(0, 1, 200, 10, 90, 30, 0);
        send_pixel(8'd200, 1'b0);
        send_pixel(8'd10, 1'b0);
        drain_results();
        set_block(1, 0, 17, 250, 240, 3, 0);
        send_pixel(8'd17, 1'b0);
        send_pixel(8'd240, 1'b0);
        drain_results();
    endtask

    // Shrink both spans below the current offsets partway through a block
    task automatic test_span_change_mid_block();
        set_block(3, 2, 40, 220, 180, 5, 3);
        repeat (4) send_pixel(8'($urandom_range(0, 255)), 1'b0);
        drain_results();
        cfg_write(CFG_COL_SPAN, CFG_BITS'(0));
        send_pixel(8'd100, 1'b0);
        drain_results();
        cfg_write(CFG_ROW_SPAN, CFG_BITS'(1));
        send_pixel(8'd100, 1'b0);
        drain_results();
    endtask

    // Upper data bits on grey registers and the unused index must be ignored
    task automatic test_register_masking();
        cfg_write(CFG_ROW_SPAN, CFG_BITS'(SPAN_MAX));
        cfg_write(CFG_COL_SPAN, CFG_BITS'(SPAN_MAX));
        cfg_write(CFG_CORNER_TL, CFG_BITS'('h3FF));
        cfg_write(CFG_CORNER_TR, CFG_BITS'('h300));
        cfg_write(CFG_CORNER_BL, CFG_BITS'('h2C3));
        cfg_write(CFG_CORNER_BR, CFG_BITS'('h101));
        cfg_write(CFG_TOLERANCE, CFG_BITS'('h300));
        cfg_write(CFG_UNUSED, '1);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b0);
        drain_results();
    endtask

    // Hold the output long enough that the block backs up into its input
    task automatic test_output_backpressure();
        set_block(1, 2, 60, 70, 80, 90, 8);
        rx_hold_len = HOLD_CYCLES;
        repeat (6) send_pixel(8'($urandom_range(60, 90)), 1'b0);
        drain_results();
    endtask

    function automatic int pick_span();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return SPAN_MAX;
            2: return $urandom_range(5, 40);
            default: return $urandom_range(1, 4);
        endcase
    endfunction

    function automatic int pick_grey();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 1) ? 255 : 0;
        return $urandom_range(0, 255);
    endfunction

    function automatic int pick_tolerance();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 255;
            2: return $urandom_range(0, 255);
            default: return $urandom_range(0, 6);
        endcase
    endfunction

    task automatic test_random_blocks();
        int target, kind, n_blk, npix, rs, cs, t, v;
        logic [CFG_BITS-1:0] word;
        logic [7:0] pix;
        logic mk;
        target = n_pixels + RANDOM_PIXELS;
        while (n_pixels < target) begin
            // quiet finish: no idling on either side near the end
            if (target - n_pixels < 60) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            drain_results();
            rs = pick_span();
            cs = pick_span();
            cfg_write(CFG_ROW_SPAN, CFG_BITS'(rs));
            cfg_write(CFG_COL_SPAN, CFG_BITS'(cs));
            word = CFG_BITS'($urandom);
            word[7:0] = 8'(pick_grey());
            cfg_write(CFG_CORNER_TL, word);
            word = CFG_BITS'($urandom);
            word[7:0] = 8'(pick_grey());
            cfg_write(CFG_CORNER_TR, word);
            word = CFG_BITS'($urandom);
            word[7:0] = 8'(pick_grey());
            cfg_write(CFG_CORNER_BL, word);
            word = CFG_BITS'($urandom);
            word[7:0] = 8'(pick_grey());
            cfg_write(CFG_CORNER_BR, word);
            word = CFG_BITS'($urandom);
            word[7:0] = 8'(pick_tolerance());
            cfg_write(CFG_TOLERANCE, word);
            if ($urandom_range(0, 7) == 0)
                cfg_write(CFG_UNUSED, CFG_BITS'($urandom));

            kind  = $urandom_range(0, 9);
            n_blk = $urandom_range(1, 3);
            repeat (n_blk) begin
                npix = (rs + 1) * (cs + 1);
                if (npix > 64)
                    npix = $urandom_range(1, 40);
                // broken block: stop partway, the next settings land mid block
                if (kind == 9)
                    npix = $urandom_range(1, npix);
                repeat (npix) begin
                    if (kind == 7 || kind == 8) begin
                        pix = 8'($urandom_range(0, 255));
                        mk  = 1'($urandom_range(0, 1));
                    end else begin
                        t = int'(tol_q);
                        v = int'(prediction_here()) + int'($urandom_range(0, 2 * t + 2)) - (t + 1);
                        if (v < 0)
                            v = 0;
                        if (v > 255)
                            v = 255;
                        pix = 8'(v);
                        mk  = ($urandom_range(0, 19) == 0);
                    end
                    send_pixel(pix, mk);
                end
            end
        end
    endtask

    initial begin
        fit_model_reset();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_corner_extremes();
        test_zero_span();
        test_span_change_mid_block();
        test_register_masking();
        test_output_backpressure();
        test_random_blocks();

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d pixels, %0d finished blocks, %0d register writes;",
                 n_pixels, n_blocks, n_cfg_writes);
        $display("zero and full spans, spans cut mid block and a long output hold included.");
        if (n_errors == 0 && expected_fits.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d errors, %0d results never arrived", n_errors, expected_fits.size());
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/bfc_pkg.sv
rtl/core/bfc_div.sv
rtl/core/bilinear_block_fit_check.sv
bench/tb_bilinear_block_fit_check.sv
